// ===== rtl/clcd_pkg.sv =====
// Shared types, codes, microcode and power-up table for the character LCD nibble sequencer.
package clcd_pkg;

    // Command codes carried by an input item
    typedef enum logic [2:0] {
        CMD_DATA      = 3'd0,
        CMD_INSTR     = 3'd1,
        CMD_LINE      = 3'd2,
        CMD_BACKLIGHT = 3'd3,
        CMD_INIT      = 3'd4
    } cmd_e_t;

    // Configuration register indexes
    localparam logic CFG_PULSE_HOLD = 1'b0;
    localparam logic CFG_INIT_GAP   = 1'b1;

    localparam logic [7:0] PULSE_HOLD_RESET = 8'd1;
    localparam logic [7:0] INIT_GAP_RESET   = 8'd5;

    // DDRAM address bytes for display lines 1 and 2
    localparam logic [1:0] LINE_ONE     = 2'd1;
    localparam logic [1:0] LINE_TWO     = 2'd2;
    localparam logic [7:0] LINE_ONE_ADDR = 8'h80;
    localparam logic [7:0] LINE_TWO_ADDR = 8'hC0;

    // Power-up table
    localparam int          INIT_LEN      = 9;
    localparam logic [3:0]  INIT_LAST_IDX = 4'(INIT_LEN - 1);

    // Microprogram entry points
    localparam logic [2:0] STEP_HI     = 3'd0;
    localparam logic [2:0] STEP_BL     = 3'd4;
    localparam logic [2:0] STEP_GAP    = 3'd5;
    localparam logic [2:0] STEP_FINISH = 3'd6;

    typedef enum logic [1:0] {EN_KEEP, EN_SET, EN_CLR} en_op_t;
    typedef enum logic [1:0] {SEL_KEEP, SEL_RS, SEL_SET} sel_op_t;
    typedef enum logic [1:0] {NIB_KEEP, NIB_HI, NIB_LO} nib_op_t;
    typedef enum logic [1:0] {HOLD_PULSE, HOLD_GAP, HOLD_ZERO} hold_op_t;
    typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_IF_SINGLE} last_op_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_GOTO, SEQ_DONE, SEQ_BYTE_END} seq_op_t;

    // One control word; every step emits one result
    typedef struct packed {
        en_op_t     en_op;
        sel_op_t    sel_op;
        nib_op_t    nib_op;
        hold_op_t   hold_op;
        logic       load_tbl;
        logic       set_bl;
        last_op_t   last_op;
        seq_op_t    seq_op;
        logic [2:0] target;
    } ucode_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic [1:0] line_number;
        logic       backlight_on;
    } item_t;

    typedef struct packed {
        logic       enable_pin;
        logic       select_pin;
        logic       readwrite_pin;
        logic [3:0] data_nibble;
        logic       backlight_pin_n;
        logic [7:0] hold_ticks;
        logic       backlight_status;
        logic       last;
    } result_t;

    function automatic ucode_t ucode_rom(input logic [2:0] pc);
        ucode_t w;
        w = '{EN_KEEP, SEL_KEEP, NIB_KEEP, HOLD_ZERO, 1'b0, 1'b0, LAST_NO, SEQ_DONE, 3'd0};
        case (pc)
            3'd0: w = '{EN_SET,  SEL_RS,   NIB_HI,   HOLD_PULSE, 1'b0, 1'b0,
                        LAST_NO, SEQ_NEXT, 3'd0};
            3'd1: w = '{EN_CLR,  SEL_KEEP, NIB_KEEP, HOLD_PULSE, 1'b0, 1'b0,
                        LAST_NO, SEQ_NEXT, 3'd0};
            3'd2: w = '{EN_SET,  SEL_KEEP, NIB_LO,   HOLD_PULSE, 1'b0, 1'b0,
                        LAST_NO, SEQ_NEXT, 3'd0};
            3'd3: w = '{EN_CLR,  SEL_KEEP, NIB_KEEP, HOLD_PULSE, 1'b0, 1'b0,
                        LAST_IF_SINGLE, SEQ_BYTE_END, 3'd0};
            3'd4: w = '{EN_KEEP, SEL_KEEP, NIB_KEEP, HOLD_ZERO,  1'b0, 1'b1,
                        LAST_YES, SEQ_DONE, 3'd0};
            3'd5: w = '{EN_KEEP, SEL_KEEP, NIB_KEEP, HOLD_GAP,   1'b1, 1'b0,
                        LAST_NO, SEQ_GOTO, STEP_HI};
            3'd6: w = '{EN_SET,  SEL_SET,  NIB_KEEP, HOLD_PULSE, 1'b0, 1'b0,
                        LAST_NO, SEQ_NEXT, 3'd0};
            3'd7: w = '{EN_CLR,  SEL_KEEP, NIB_KEEP, HOLD_ZERO,  1'b0, 1'b0,
                        LAST_YES, SEQ_DONE, 3'd0};
            default: w = '{EN_KEEP, SEL_KEEP, NIB_KEEP, HOLD_ZERO, 1'b0, 1'b0,
                           LAST_NO, SEQ_DONE, 3'd0};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] power_up_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h30;
            4'd1:    b = 8'h30;
            4'd2:    b = 8'h30;
            4'd3:    b = 8'h20;
            4'd4:    b = 8'h28;
            4'd5:    b = 8'h08;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h07;
            4'd8:    b = 8'hA0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/clcd_useq.sv =====
// Microcoded step sequencer and pin-level datapath for the character LCD nibble writer.
module clcd_useq
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  item_t      item,
    input  logic [7:0] pulse_hold,
    input  logic [7:0] init_gap,
    input  logic       advance,
    output logic       busy,
    output logic       emit,
    output result_t    res
);

    logic       busy_reg, busy_next;
    logic [2:0] pc_reg, pc_next;
    logic       init_reg, init_next;
    logic [3:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic       rs_reg, rs_next;
    logic       bl_req_reg, bl_req_next;
    logic       enable_reg, enable_next;
    logic       select_reg, select_next;
    logic [3:0] nibble_reg, nibble_next;
    logic       backlight_reg, backlight_next;

    ucode_t     uw;
    logic       go;
    logic [2:0] pc_start;
    logic       rs_start;
    logic [7:0] byte_start;
    logic       init_start;

    // Command decode at accept
    always_comb
    begin
        go         = 1'b0;
        pc_start   = STEP_HI;
        rs_start   = 1'b0;
        byte_start = item.data_byte;
        init_start = 1'b0;
        case (item.command)
            CMD_DATA:
            begin
                go       = 1'b1;
                rs_start = 1'b1;
            end
            CMD_INSTR:
            begin
                go = 1'b1;
            end
            CMD_LINE:
            begin
                if (item.line_number == LINE_ONE)
                begin
                    go         = 1'b1;
                    byte_start = LINE_ONE_ADDR;
                end
                else if (item.line_number == LINE_TWO)
                begin
                    go         = 1'b1;
                    byte_start = LINE_TWO_ADDR;
                end
            end
            CMD_BACKLIGHT:
            begin
                go       = 1'b1;
                pc_start = STEP_BL;
            end
            CMD_INIT:
            begin
                go         = 1'b1;
                pc_start   = STEP_GAP;
                init_start = 1'b1;
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
    end

    assign emit = busy_reg && advance;
    assign busy = busy_reg;

    always_comb
    begin
        uw             = ucode_rom(pc_reg);
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        init_next      = init_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        rs_next        = rs_reg;
        bl_req_next    = bl_req_reg;
        enable_next    = enable_reg;
        select_next    = select_reg;
        nibble_next    = nibble_reg;
        backlight_next = backlight_reg;
        res            = '0;

        if (start && !busy_reg)
        begin
            busy_next   = go;
            pc_next     = pc_start;
            init_next   = init_start;
            idx_next    = '0;
            byte_next   = byte_start;
            rs_next     = rs_start;
            bl_req_next = item.backlight_on;
        end
        else if (emit)
        begin
            case (uw.en_op)
                EN_SET:  enable_next = 1'b1;
                EN_CLR:  enable_next = 1'b0;
                default: enable_next = enable_reg;
            endcase
            case (uw.sel_op)
                SEL_RS:  select_next = rs_reg;
                SEL_SET: select_next = 1'b1;
                default: select_next = select_reg;
            endcase
            case (uw.nib_op)
                NIB_HI:  nibble_next = byte_reg[7:4];
                NIB_LO:  nibble_next = byte_reg[3:0];
                default: nibble_next = nibble_reg;
            endcase
            if (uw.set_bl)
            begin
                backlight_next = bl_req_reg;
            end
            if (uw.load_tbl)
            begin
                byte_next = power_up_byte(idx_reg);
            end

            res.enable_pin       = enable_next;
            res.select_pin       = select_next;
            res.readwrite_pin    = 1'b0;
            res.data_nibble      = nibble_next;
            res.backlight_pin_n  = ~backlight_next;
            res.backlight_status = backlight_next;
            case (uw.hold_op)
                HOLD_PULSE: res.hold_ticks = pulse_hold;
                HOLD_GAP:   res.hold_ticks = init_gap;
                default:    res.hold_ticks = 8'd0;
            endcase
            case (uw.last_op)
                LAST_YES:       res.last = 1'b1;
                LAST_IF_SINGLE: res.last = !init_reg;
                default:        res.last = 1'b0;
            endcase

            case (uw.seq_op)
                SEQ_NEXT: pc_next = pc_reg + 3'd1;
                SEQ_GOTO: pc_next = uw.target;
                SEQ_BYTE_END:
                begin
                    if (!init_reg)
                    begin
                        busy_next = 1'b0;
                    end
                    else if (idx_reg == INIT_LAST_IDX)
                    begin
                        pc_next = STEP_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                        pc_next  = STEP_GAP;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= STEP_HI;
            init_reg      <= 1'b0;
            idx_reg       <= '0;
            enable_reg    <= 1'b0;
            select_reg    <= 1'b0;
            nibble_reg    <= '0;
            backlight_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            init_reg      <= init_next;
            idx_reg       <= idx_next;
            enable_reg    <= enable_next;
            select_reg    <= select_next;
            nibble_reg    <= nibble_next;
            backlight_reg <= backlight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        rs_reg     <= rs_next;
        bl_req_reg <= bl_req_next;
    end

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer.sv =====
// Top level of the character LCD 4-bit write sequencer: stream ports, config, output register.
// Turns commands into pin-phase items for an HD44780-style LCD in 4-bit mode. Each accepted
// command runs a short microprogram that emits one result item per clock: a byte write
// (data, instruction, or line select 1/2 -> address 0x80/0xC0) gives four items (E high with
// the high nibble, E low, E high with the low nibble, E low); backlight gives one item; init
// gives 47 items (a gap item plus a byte write for each of nine table bytes, then an E pulse).
// Line numbers other than 1 or 2 and command codes 5..7 give no items. Throughput is one
// result per cycle, set by the single step counter, stalling while m_tready is low; a new
// command is taken in the cycle after the last step of the previous one, while its final
// item may still sit in the output register. Config writes are taken on any cycle, but are
// meant for idle time only.
module char_lcd_nibble_write_sequencer
    import clcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // command items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[2:0], data_byte[10:3], line_number[12:11],
                                   // backlight_on[13], zero[15:14]
    // pin-phase items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // enable_pin[0], select_pin[1], readwrite_pin[2],
                                   // data_nibble[6:3], backlight_pin_n[7], hold_ticks[15:8],
                                   // backlight_status[16], zero[23:17]
    output logic        m_tlast
);

    logic [7:0] pulse_hold_reg;
    logic [7:0] init_gap_reg;
    logic       m_tvalid_reg, m_tvalid_next;
    result_t    res_reg;

    item_t      item;
    result_t    res;
    logic       busy;
    logic       emit;
    logic       advance;
    logic       start;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_hold_reg <= PULSE_HOLD_RESET;
            init_gap_reg   <= INIT_GAP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PULSE_HOLD)
            begin
                pulse_hold_reg <= cfg_data;
            end
            else
            begin
                init_gap_reg <= cfg_data;
            end
        end
    end

    // unpack command item
    assign item.command      = s_tdata[2:0];
    assign item.data_byte    = s_tdata[10:3];
    assign item.line_number  = s_tdata[12:11];
    assign item.backlight_on = s_tdata[13];

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    // step only when the output register is free or being drained
    assign advance = !m_tvalid_reg || m_tready;

    clcd_useq u_useq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .pulse_hold (pulse_hold_reg),
        .init_gap   (init_gap_reg),
        .advance    (advance),
        .busy       (busy),
        .emit       (emit),
        .res        (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0,
                       res_reg.backlight_status,
                       res_reg.hold_ticks,
                       res_reg.backlight_pin_n,
                       res_reg.data_nibble,
                       res_reg.readwrite_pin,
                       res_reg.select_pin,
                       res_reg.enable_pin};
    assign m_tlast  = res_reg.last;

endmodule
